[src/kst_pkg.sv]
// Package for the keyboard scancode translator: sizes, scancodes, command
// and register codes, the set-1 key table and the structs passed between blocks.
// No dependencies.
package kst_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TABLE_KEYS  = 58;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int TAB_W       = $clog2(TABLE_KEYS);
  localparam int KEYS        = 128;

  localparam int CHAR_W      = 8;
  localparam int CMD_W       = 2;
  localparam int LEVEL_W     = 7;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int ARROWS      = 4;

  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_UP    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DOWN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEFT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT = 3'd3;

  localparam logic [CHAR_W-1:0] RST_UP    = 8'd17;
  localparam logic [CHAR_W-1:0] RST_DOWN  = 8'd18;
  localparam logic [CHAR_W-1:0] RST_LEFT  = 8'd19;
  localparam logic [CHAR_W-1:0] RST_RIGHT = 8'd20;

  localparam logic [7:0] SC_CTRL        = 8'h1D;
  localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
  localparam logic [7:0] SC_SHIFT_L     = 8'h2A;
  localparam logic [7:0] SC_SHIFT_R     = 8'h36;
  localparam logic [7:0] SC_SHL_BRK     = 8'hAA;
  localparam logic [7:0] SC_SHR_BRK     = 8'hB6;
  localparam logic [7:0] SC_CAPS        = 8'h3A;
  localparam logic [7:0] SC_ARROW_UP    = 8'h48;
  localparam logic [7:0] SC_ARROW_DOWN  = 8'h50;
  localparam logic [7:0] SC_ARROW_LEFT  = 8'h4B;
  localparam logic [7:0] SC_ARROW_RIGHT = 8'h4D;

  localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z_LO = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_R_LO = 8'h72;
  localparam logic [CHAR_W-1:0] CHAR_R_UP = 8'h52;
  localparam logic [CHAR_W-1:0] CASE_GAP  = 8'd32;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              snap;
    logic              key_down;
  } kst_key_res_t;

  typedef struct packed {
    logic               queued;
    logic               dropped;
    logic               popped;
    logic [LEVEL_W-1:0] level;
  } kst_q_res_t;

  // Returns {unshifted, shifted} for one set-1 make code.
  function automatic logic [2*CHAR_W-1:0] key_lookup(input logic [TAB_W-1:0] idx);
    logic [2*CHAR_W-1:0] r;
    case (idx)
      6'd1:  r = {8'h1B, 8'h1B};
      6'd2:  r = {8'h31, 8'h21};
      6'd3:  r = {8'h32, 8'h40};
      6'd4:  r = {8'h33, 8'h23};
      6'd5:  r = {8'h34, 8'h24};
      6'd6:  r = {8'h35, 8'h25};
      6'd7:  r = {8'h36, 8'h5E};
      6'd8:  r = {8'h37, 8'h26};
      6'd9:  r = {8'h38, 8'h2A};
      6'd10: r = {8'h39, 8'h28};
      6'd11: r = {8'h30, 8'h29};
      6'd12: r = {8'h2D, 8'h5F};
      6'd13: r = {8'h3D, 8'h2B};
      6'd14: r = {8'h08, 8'h08};
      6'd15: r = {8'h09, 8'h09};
      6'd16: r = {8'h71, 8'h51};
      6'd17: r = {8'h77, 8'h57};
      6'd18: r = {8'h65, 8'h45};
      6'd19: r = {8'h72, 8'h52};
      6'd20: r = {8'h74, 8'h54};
      6'd21: r = {8'h79, 8'h59};
      6'd22: r = {8'h75, 8'h55};
      6'd23: r = {8'h69, 8'h49};
      6'd24: r = {8'h6F, 8'h4F};
      6'd25: r = {8'h70, 8'h50};
      6'd26: r = {8'h5B, 8'h7B};
      6'd27: r = {8'h5D, 8'h7D};
      6'd28: r = {8'h0A, 8'h0A};
      6'd30: r = {8'h61, 8'h41};
      6'd31: r = {8'h73, 8'h53};
      6'd32: r = {8'h64, 8'h44};
      6'd33: r = {8'h66, 8'h46};
      6'd34: r = {8'h67, 8'h47};
      6'd35: r = {8'h68, 8'h48};
      6'd36: r = {8'h6A, 8'h4A};
      6'd37: r = {8'h6B, 8'h4B};
      6'd38: r = {8'h6C, 8'h4C};
      6'd39: r = {8'h3B, 8'h3A};
      6'd40: r = {8'h27, 8'h22};
      6'd41: r = {8'h60, 8'h7E};
      6'd43: r = {8'h5C, 8'h7C};
      6'd44: r = {8'h7A, 8'h5A};
      6'd45: r = {8'h78, 8'h58};
      6'd46: r = {8'h63, 8'h43};
      6'd47: r = {8'h76, 8'h56};
      6'd48: r = {8'h62, 8'h42};
      6'd49: r = {8'h6E, 8'h4E};
      6'd50: r = {8'h6D, 8'h4D};
      6'd51: r = {8'h2C, 8'h3C};
      6'd52: r = {8'h2E, 8'h3E};
      6'd53: r = {8'h2F, 8'h3F};
      6'd57: r = {8'h20, 8'h20};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/kst_in_if.sv]
// Input channel of the scancode translator: valid/ready plus command and code.
// Depends on kst_pkg.
interface kst_in_if;
  logic                       valid;
  logic                       ready;
  logic [kst_pkg::CMD_W-1:0]  cmd;
  logic [7:0]                 scan_code;

  modport source (output valid, output cmd, output scan_code, input ready);
  modport sink   (input valid, input cmd, input scan_code, output ready);
endinterface

[src/kst_out_if.sv]
// Result channel of the scancode translator: valid/ready plus the result fields.
// Depends on kst_pkg.
interface kst_out_if;
  logic                         valid;
  logic                         ready;
  logic [kst_pkg::CHAR_W-1:0]   read_char;
  logic                         key_down;
  logic                         char_queued;
  logic                         char_dropped;
  logic                         snapshot_request;
  logic [kst_pkg::LEVEL_W-1:0]  queue_level;

  modport source (output valid, output read_char, output key_down, output char_queued,
                  output char_dropped, output snapshot_request, output queue_level,
                  input ready);
  modport sink   (input valid, input read_char, input key_down, input char_queued,
                  input char_dropped, input snapshot_request, input queue_level,
                  output ready);
endinterface

[src/kst_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/kst_keys.sv]
// Modifier flags, key-down map, arrow code registers and set-1 translation.
// Depends on kst_pkg.
module kst_keys (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [kst_pkg::CMD_W-1:0]       cmd,
  input  logic [7:0]                      scan_code,
  input  logic                            cfg_we,
  input  logic [kst_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [kst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output kst_pkg::kst_key_res_t           res
);

  logic                          ctrl_r, ctrl_nxt, shift_r, shift_nxt, caps_r, caps_nxt;
  logic                          ctrl_f, shift_f, caps_f;
  logic [kst_pkg::KEYS-1:0]      key_map_r, key_map_nxt;
  logic [kst_pkg::CHAR_W-1:0]    arrow_r [kst_pkg::ARROWS];
  logic [kst_pkg::CHAR_W-1:0]    arrow_ch, table_ch, ch;
  logic [2*kst_pkg::CHAR_W-1:0]  rom_pair;
  logic                          is_scan;

  assign is_scan = (cmd == kst_pkg::CMD_SCAN);

  always_comb begin
    ctrl_f  = ctrl_r;
    shift_f = shift_r;
    caps_f  = caps_r;
    case (scan_code)
      kst_pkg::SC_CTRL:                          ctrl_f  = 1'b1;
      kst_pkg::SC_CTRL_BRK:                      ctrl_f  = 1'b0;
      kst_pkg::SC_SHIFT_L, kst_pkg::SC_SHIFT_R:  shift_f = 1'b1;
      kst_pkg::SC_SHL_BRK, kst_pkg::SC_SHR_BRK:  shift_f = 1'b0;
      kst_pkg::SC_CAPS:                          caps_f  = ~caps_r;
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl_nxt    = ctrl_r;
    shift_nxt   = shift_r;
    caps_nxt    = caps_r;
    key_map_nxt = key_map_r;
    if (accept && is_scan) begin
      ctrl_nxt  = ctrl_f;
      shift_nxt = shift_f;
      caps_nxt  = caps_f;
      key_map_nxt[scan_code[6:0]] = ~scan_code[7];
    end
  end

  always_comb begin
    case (scan_code)
      kst_pkg::SC_ARROW_UP:    arrow_ch = arrow_r[kst_pkg::CFG_UP[1:0]];
      kst_pkg::SC_ARROW_DOWN:  arrow_ch = arrow_r[kst_pkg::CFG_DOWN[1:0]];
      kst_pkg::SC_ARROW_LEFT:  arrow_ch = arrow_r[kst_pkg::CFG_LEFT[1:0]];
      kst_pkg::SC_ARROW_RIGHT: arrow_ch = arrow_r[kst_pkg::CFG_RIGHT[1:0]];
      default:                 arrow_ch = '0;
    endcase
  end

  assign rom_pair = kst_pkg::key_lookup(scan_code[kst_pkg::TAB_W-1:0]);

  always_comb begin
    table_ch = '0;
    if (scan_code < 8'(kst_pkg::TABLE_KEYS)) begin
      table_ch = shift_f ? rom_pair[kst_pkg::CHAR_W-1:0]
                         : rom_pair[2*kst_pkg::CHAR_W-1:kst_pkg::CHAR_W];
      if (caps_f && table_ch >= kst_pkg::CHAR_A_LO && table_ch <= kst_pkg::CHAR_Z_LO) begin
        table_ch = table_ch - kst_pkg::CASE_GAP;
      end
    end
    ch = (arrow_ch != '0) ? arrow_ch : table_ch;
  end

  always_comb begin
    res.ch       = is_scan ? ch : '0;
    res.snap     = is_scan && ctrl_f && (ch == kst_pkg::CHAR_R_LO || ch == kst_pkg::CHAR_R_UP);
    res.key_down = (cmd == kst_pkg::CMD_QUERY) && !scan_code[7] && key_map_r[scan_code[6:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= 1'b0;
      shift_r   <= 1'b0;
      caps_r    <= 1'b0;
      key_map_r <= '0;
      arrow_r[kst_pkg::CFG_UP[1:0]]    <= kst_pkg::RST_UP;
      arrow_r[kst_pkg::CFG_DOWN[1:0]]  <= kst_pkg::RST_DOWN;
      arrow_r[kst_pkg::CFG_LEFT[1:0]]  <= kst_pkg::RST_LEFT;
      arrow_r[kst_pkg::CFG_RIGHT[1:0]] <= kst_pkg::RST_RIGHT;
    end else begin
      ctrl_r    <= ctrl_nxt;
      shift_r   <= shift_nxt;
      caps_r    <= caps_nxt;
      key_map_r <= key_map_nxt;
      if (cfg_we && cfg_addr < 3'(kst_pkg::ARROWS)) begin
        arrow_r[cfg_addr[1:0]] <= cfg_wdata;
      end
    end
  end

  a_caps_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_scan && scan_code == kst_pkg::SC_CAPS) |=> (caps_r != $past(caps_r)))
    else $error("caps lock did not toggle on its make code");

endmodule

[src/kst_queue.sv]
// Character FIFO: pointers and fill count around a registered-read RAM.
// Depends on kst_pkg and kst_ram.
module kst_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         push_req,
  input  logic                         pop_req,
  input  logic [kst_pkg::CHAR_W-1:0]   wdata,
  output kst_pkg::kst_q_res_t          res,
  output logic [kst_pkg::CHAR_W-1:0]   rdata
);

  logic [kst_pkg::PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [kst_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        full, empty, do_push, do_pop;

  assign full    = (count_r == kst_pkg::COUNT_W'(kst_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = accept && push_req && !full;
  assign do_pop  = accept && pop_req && !empty;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == kst_pkg::PTR_W'(kst_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == kst_pkg::PTR_W'(kst_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_comb begin
    res.queued  = do_push;
    res.dropped = accept && push_req && full;
    res.popped  = do_pop;
    res.level   = kst_pkg::LEVEL_W'(count_nxt);
  end

  kst_ram #(
    .WIDTH (kst_pkg::CHAR_W),
    .DEPTH (kst_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_ptr_r),
    .wdata (wdata),
    .re    (do_pop),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kst_pkg::COUNT_W'(kst_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) |-> (empty || full))
    else $error("pointers equal with a partly filled queue");

  a_ptrs_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers apart with an empty or full queue");

endmodule

[src/keyboard_scancode_translator_fifo.sv]
// Top level of the set-1 scancode translator with its character queue.
// Depends on kst_pkg, kst_in_if, kst_out_if, kst_keys and kst_queue.
//
// One beat is accepted per clock cycle while the result channel is not stalled, and
// every beat yields exactly one result beat. Flags, the key-down map and the queue
// pointers update in the acceptance cycle; the result then passes the stage-1 registers
// and the registered read of the 64-entry character RAM, then the output register.
// The queue RAM needs no clearing pass after reset. Arrow codes are to be written through
// the cfg port only while the block is idle; the block itself does not enforce this.
module keyboard_scancode_translator_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  kst_in_if.sink                          in_ch,
  kst_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [kst_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [kst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  kst_pkg::kst_key_res_t        key_res;
  kst_pkg::kst_q_res_t          q_res;
  logic [kst_pkg::CHAR_W-1:0]   q_rdata;
  logic                         accept, push_req, s1_adv;

  logic                         s1_valid_r;
  kst_pkg::kst_key_res_t        s1_key_r;
  kst_pkg::kst_q_res_t          s1_q_r;

  logic                         out_valid_r;
  logic [kst_pkg::CHAR_W-1:0]   out_char_r;
  logic                         out_kd_r, out_queued_r, out_dropped_r, out_snap_r;
  logic [kst_pkg::LEVEL_W-1:0]  out_level_r;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_req    = (key_res.ch != '0) && !key_res.snap;

  kst_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_ch.cmd),
    .scan_code (in_ch.scan_code),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .res       (key_res)
  );

  kst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .push_req (push_req),
    .pop_req  (in_ch.cmd == kst_pkg::CMD_READ),
    .wdata    (key_res.ch),
    .res      (q_res),
    .rdata    (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r <= key_res;
      s1_q_r   <= q_res;
    end
    if (s1_adv && s1_valid_r) begin
      out_char_r    <= s1_q_r.popped ? q_rdata : '0;
      out_kd_r      <= s1_key_r.key_down;
      out_queued_r  <= s1_q_r.queued;
      out_dropped_r <= s1_q_r.dropped;
      out_snap_r    <= s1_key_r.snap;
      out_level_r   <= s1_q_r.level;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.read_char        = out_char_r;
  assign out_ch.key_down         = out_kd_r;
  assign out_ch.char_queued      = out_queued_r;
  assign out_ch.char_dropped     = out_dropped_r;
  assign out_ch.snapshot_request = out_snap_r;
  assign out_ch.queue_level      = out_level_r;

  a_popped_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_q_r.popped) |-> (q_rdata != '0))
    else $error("popped a zero character from the queue");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_queued_r && out_dropped_r) || (out_queued_r && out_snap_r)
                      || (out_dropped_r && out_snap_r)))
    else $error("more than one scancode outcome flagged in a beat");

endmodule

[dv/keyboard_scancode_translator_fifo_test.sv]
// Self-checking testbench for keyboard_scancode_translator_fifo: drives scancode,
// read and query beats, predicts every result beat and compares it field by field.
// Depends on kst_pkg, kst_in_if, kst_out_if and the block itself.
module keyboard_scancode_translator_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kst_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;
  localparam logic [7:0]       BREAK_FLAG  = 8'h80;
  localparam logic [7:0]       KEY_R       = 8'h13;
  localparam int               QUIET_LIMIT = 400;

  localparam logic [7:0] PLAIN_CHARS [TABLE_KEYS] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
  };
  localparam logic [7:0] SHIFT_CHARS [TABLE_KEYS] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20
  };
  localparam logic [7:0] MODIFIER_CODES [7] = '{
    SC_CTRL, SC_CTRL_BRK, SC_SHIFT_L, SC_SHIFT_R, SC_SHL_BRK, SC_SHR_BRK, SC_CAPS
  };
  localparam logic [7:0] ARROW_CODES [ARROWS] = '{
    SC_ARROW_UP, SC_ARROW_DOWN, SC_ARROW_LEFT, SC_ARROW_RIGHT
  };

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       code;
  } key_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  read_char;
    logic               key_down;
    logic               char_queued;
    logic               char_dropped;
    logic               snapshot_request;
    logic [LEVEL_W-1:0] queue_level;
  } key_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic             send_valid = 1'b0;
  logic [CMD_W-1:0] send_cmd = '0;
  logic [7:0]       send_code = '0;
  logic             take_ready = 1'b0;

  kst_in_if  in_bus ();
  kst_out_if out_bus ();

  assign in_bus.valid     = send_valid;
  assign in_bus.cmd       = send_cmd;
  assign in_bus.scan_code = send_code;
  assign out_bus.ready    = take_ready;

  keyboard_scancode_translator_fifo i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's state.
  logic [7:0]      arrow_code [ARROWS] = '{RST_UP, RST_DOWN, RST_LEFT, RST_RIGHT};
  logic [7:0]      held_chars [$];
  logic [KEYS-1:0] keys_pressed = '0;
  logic            shift_on = 1'b0;
  logic            caps_lock = 1'b0;
  logic            ctrl_on = 1'b0;

  key_item_t   pending [$];
  key_result_t expected [$];
  logic [7:0]  last_make = 8'h00;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   idle_odds = 8;
  int   send_gap = 0;
  int   hold_gap = 0;
  int   quiet = 0;
  int   errors = 0;
  int   beats_in = 0;
  int   beats_checked = 0;
  int   n_queued = 0;
  int   n_dropped = 0;
  int   n_snap = 0;
  int   n_empty_reads = 0;

  function automatic key_result_t next_keyboard_result(input logic [CMD_W-1:0] cmd,
                                                       input logic [7:0] code);
    key_result_t r;
    logic [7:0]  ch;
    r = '0;
    ch = 8'h00;
    case (cmd)
      CMD_SCAN: begin
        if (code == SC_CTRL) ctrl_on = 1'b1;
        else if (code == SC_CTRL_BRK) ctrl_on = 1'b0;
        else if (code == SC_SHIFT_L || code == SC_SHIFT_R) shift_on = 1'b1;
        else if (code == SC_SHL_BRK || code == SC_SHR_BRK) shift_on = 1'b0;
        else if (code == SC_CAPS) caps_lock = !caps_lock;
        keys_pressed[code[6:0]] = !code[7];
        if (code == SC_ARROW_UP) ch = arrow_code[CFG_UP];
        else if (code == SC_ARROW_DOWN) ch = arrow_code[CFG_DOWN];
        else if (code == SC_ARROW_LEFT) ch = arrow_code[CFG_LEFT];
        else if (code == SC_ARROW_RIGHT) ch = arrow_code[CFG_RIGHT];
        if (ch == 8'h00 && code < TABLE_KEYS) begin
          ch = shift_on ? SHIFT_CHARS[code] : PLAIN_CHARS[code];
          if (caps_lock && ch >= CHAR_A_LO && ch <= CHAR_Z_LO) ch = ch - CASE_GAP;
        end
        if (ctrl_on && (ch == CHAR_R_LO || ch == CHAR_R_UP)) begin
          r.snapshot_request = 1'b1;
          n_snap++;
        end else if (ch != 8'h00) begin
          if (held_chars.size() >= QUEUE_DEPTH) begin
            r.char_dropped = 1'b1;
            n_dropped++;
          end else begin
            held_chars.push_back(ch);
            r.char_queued = 1'b1;
            n_queued++;
          end
        end
      end
      CMD_READ: begin
        if (held_chars.size() != 0) r.read_char = held_chars.pop_front();
        else n_empty_reads++;
      end
      CMD_QUERY: begin
        if (code < KEYS) r.key_down = keys_pressed[code[6:0]];
      end
      default: begin
      end
    endcase
    r.queue_level = LEVEL_W'(held_chars.size());
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s got 0x%02h expected 0x%02h",
                           beats_checked, name, got, want));
  endtask

  // Input side: holds a beat until it is taken, idles in bursts between beats.
  always @(negedge clk) begin
    if (send_valid && in_taken) void'(pending.pop_front());
    if (!rst_n) begin
      send_valid <= 1'b0;
    end else if (!send_valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        send_valid <= 1'b0;
      end else if (pending.size() != 0 && idle_odds != 0 &&
                   $urandom_range(1, idle_odds) == 1) begin
        send_gap = $urandom_range(0, 17);
        send_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        send_valid <= 1'b1;
        send_cmd   <= pending[0].cmd;
        send_code  <= pending[0].code;
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (hold_gap != 0) begin
      hold_gap--;
      take_ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      hold_gap = $urandom_range(0, 17);
      take_ready <= 1'b0;
    end else begin
      take_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    key_result_t want;
    in_taken  = rst_n && in_bus.valid && in_bus.ready;
    out_taken = rst_n && out_bus.valid && out_bus.ready;
    if (rst_n && cfg_we && cfg_addr < ARROWS) arrow_code[cfg_addr] = cfg_wdata;
    if (in_taken) begin
      beats_in++;
      expected.push_back(next_keyboard_result(in_bus.cmd, in_bus.scan_code));
    end
    if (out_taken) begin
      if (expected.size() == 0) begin
        flag_error("result beat arrived with nothing outstanding");
      end else begin
        want = expected.pop_front();
        compare_field("read_char", out_bus.read_char, want.read_char);
        compare_field("key_down", 8'(out_bus.key_down), 8'(want.key_down));
        compare_field("char_queued", 8'(out_bus.char_queued), 8'(want.char_queued));
        compare_field("char_dropped", 8'(out_bus.char_dropped), 8'(want.char_dropped));
        compare_field("snapshot_request", 8'(out_bus.snapshot_request),
                      8'(want.snapshot_request));
        compare_field("queue_level", 8'(out_bus.queue_level), 8'(want.queue_level));
        beats_checked++;
      end
    end
    if (!rst_n || in_taken || out_taken || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timed out with %0d beats waiting to be sent and %0d results outstanding.",
                 pending.size(), expected.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic void add_item(input logic [CMD_W-1:0] cmd, input logic [7:0] code);
    key_item_t item;
    item.cmd  = cmd;
    item.code = code;
    pending.push_back(item);
  endfunction

  // Mostly key strokes with their releases, mixed with modifiers, reads and queries.
  task automatic add_typing(input int count, input int read_pct);
    int         made;
    int         pick;
    logic [7:0] code;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      code = 8'($urandom_range(0, 255));
      if (pick < read_pct) begin
        add_item(CMD_READ, code);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          add_item(CMD_QUERY, ($urandom_range(0, 3) == 0) ? code : last_make);
        end else if (pick < 10) begin
          add_item(CMD_SPARE, code);
        end else if (pick < 15) begin
          add_item(CMD_SCAN, code);
        end else if (pick < 23) begin
          add_item(CMD_SCAN, MODIFIER_CODES[$urandom_range(0, 6)]);
        end else begin
          if (pick < 28) code = ARROW_CODES[$urandom_range(0, ARROWS - 1)];
          else if (pick < 32) code = KEY_R;
          else code = 8'($urandom_range(0, TABLE_KEYS - 1));
          add_item(CMD_SCAN, code);
          last_make = code;
          if ($urandom_range(0, 99) < 45) begin
            add_item(CMD_SCAN, code | BREAK_FLAG);
            made++;
          end
        end
      end
      made++;
    end
  endtask

  task automatic settle();
    while (pending.size() != 0 || expected.size() != 0 || send_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_item(CMD_READ, 8'h00);
    add_item(CMD_QUERY, 8'hFF);
    add_item(CMD_SPARE, 8'hA5);
    add_item(CMD_SCAN, 8'h00);
    add_item(CMD_SCAN, 8'h1E);
    add_item(CMD_SCAN, 8'h9E);
    add_item(CMD_QUERY, 8'h1E);
    add_item(CMD_SCAN, SC_SHIFT_L);
    add_item(CMD_SCAN, 8'h02);
    add_item(CMD_SCAN, SC_SHL_BRK);
    add_item(CMD_SCAN, SC_CAPS);
    add_item(CMD_SCAN, 8'h10);
    add_item(CMD_SCAN, SC_CAPS);
    add_item(CMD_SCAN, SC_CTRL);
    add_item(CMD_SCAN, KEY_R);
    add_item(CMD_SCAN, SC_CTRL_BRK);
    add_item(CMD_SCAN, SC_ARROW_UP);
    add_item(CMD_SCAN, SC_ARROW_DOWN);
    add_item(CMD_SCAN, SC_ARROW_LEFT);
    add_item(CMD_SCAN, SC_ARROW_RIGHT);
    add_item(CMD_SCAN, 8'h39);
    add_item(CMD_SCAN, 8'hFF);
    add_item(CMD_READ, 8'hFF);
    settle();

    // Arrow codes at the extremes, including r and R to trigger snapshots.
    write_register(CFG_UP, 8'h00);
    write_register(CFG_DOWN, 8'hFF);
    write_register(CFG_LEFT, CHAR_R_LO);
    write_register(CFG_RIGHT, CHAR_R_UP);
    write_register(CFG_ADDR_W'($urandom_range(ARROWS, (1 << CFG_ADDR_W) - 1)),
                   CFG_DATA_W'($urandom_range(0, 255)));
    add_item(CMD_SCAN, SC_CTRL);
    add_item(CMD_SCAN, SC_ARROW_LEFT);
    add_item(CMD_SCAN, SC_ARROW_RIGHT);
    add_item(CMD_SCAN, SC_ARROW_UP);
    add_item(CMD_SCAN, SC_CTRL_BRK);
    add_item(CMD_SCAN, SC_ARROW_DOWN);
    settle();

    idle_odds = 12;
    add_typing(200, 3);
    settle();
    idle_odds = 5;
    add_typing(150, 35);
    settle();
    idle_odds = 40;
    add_typing(180, 65);
    settle();

    for (int i = 0; i < ARROWS; i++)
      write_register(CFG_ADDR_W'(i), CFG_DATA_W'($urandom_range(0, 255)));
    write_register(CFG_ADDR_W'($urandom_range(ARROWS, (1 << CFG_ADDR_W) - 1)),
                   CFG_DATA_W'($urandom_range(0, 255)));
    idle_odds = 10;
    add_typing(160, 5);
    settle();

    write_register(CFG_UP, RST_UP);
    write_register(CFG_DOWN, RST_DOWN);
    write_register(CFG_LEFT, RST_LEFT);
    write_register(CFG_RIGHT, RST_RIGHT);
    idle_odds = 0;
    add_typing(120, 40);
    settle();

    $display("Sent %0d beats and checked %0d results; %0d mismatches.",
             beats_in, beats_checked, errors);
    $display("Queued %0d characters, dropped %0d on a full queue, %0d snapshots, %0d empty reads.",
             n_queued, n_dropped, n_snap, n_empty_reads);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/kst_pkg.sv
src/kst_in_if.sv
src/kst_out_if.sv
src/kst_ram.sv
src/kst_keys.sv
src/kst_queue.sv
src/keyboard_scancode_translator_fifo.sv
dv/keyboard_scancode_translator_fifo_test.sv
